### rtl/core/keypad_number_entry_defines.svh
// Assertion macros shared by the keypad number entry RTL.
// Each macro takes a label, the checked expression or implication parts, and a message.
`ifndef KEYPAD_NUMBER_ENTRY_DEFINES_SVH
`define KEYPAD_NUMBER_ENTRY_DEFINES_SVH

`ifndef SYNTHESIS

// Check an expression or an overlapping implication on every clock edge out of reset.
`define KNE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define KNE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define KNE_ASSERT(label, prop, msg)
`define KNE_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

### rtl/core/kne_pkg.sv
package kne_pkg;

    localparam int LINE_COUNT = 12;
    localparam int LINE_W     = 4;
    localparam int VALUE_W    = 27;
    localparam int OUT_W      = 28;

    localparam logic [LINE_W-1:0] HASH_LINE = 4'd8;
    localparam logic [LINE_W-1:0] LAST_LINE = 4'd11;

    // Controller to datapath commands
    typedef struct packed {
        logic load;   // capture a new scan
        logic step;   // process the current line and advance
        logic emit;   // write the result word and clear entry state
    } kne_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic hash_release;  // current line is hash and was just released
        logic last_line;     // current line is the final line of the scan
        logic out_free;      // output register can take a word this cycle
    } kne_sts_t;

    // Digit carried by each keypad line; star and hash give zero
    function automatic logic [3:0] line_digit(input logic [LINE_W-1:0] line);
        logic [3:0] d;
        case (line)
            4'd1:    d = 4'd7;
            4'd2:    d = 4'd4;
            4'd3:    d = 4'd1;
            4'd5:    d = 4'd8;
            4'd6:    d = 4'd5;
            4'd7:    d = 4'd2;
            4'd9:    d = 4'd9;
            4'd10:   d = 4'd6;
            4'd11:   d = 4'd3;
            default: d = 4'd0;
        endcase
        return d;
    endfunction

endpackage

### rtl/core/kne_key_if.sv
interface kne_key_if;
    import kne_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [LINE_COUNT-1:0] key_levels;

    modport source (output valid, output key_levels, input ready);
    modport sink   (input valid, input key_levels, output ready);
endinterface

### rtl/core/kne_value_if.sv
interface kne_value_if;
    import kne_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] entered_value;

    modport source (output valid, output entered_value, input ready);
    modport sink   (input valid, input entered_value, output ready);
endinterface

### rtl/core/keypad_number_entry.sv
// Keypad number entry. Each word on keys is one scan of 12 keypad lines (bit i = line i,
// 1 = pressed, lines star,7,4,1,0,8,5,2,hash,9,6,3). A key counts on release after a press;
// digit keys append to a decimal value (star appends 0), hash release sends the value, or
// -1 when no digits were kept, on result and clears all entry state; later lines of that
// scan are skipped. At most MAX_DIGITS digits are kept, further digits are dropped. The
// controller walks the scan one line per cycle, holding on a hash release until the previous
// result word has been taken; keys is not ready from acceptance until the walk ends at the
// last line, or earlier when hash ends the scan.
// A result word sits in an output register, and the next scan is accepted while it waits.
`include "keypad_number_entry_defines.svh"

module keypad_number_entry #(
    parameter int MAX_DIGITS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    kne_key_if.sink            keys,
    kne_value_if.source        result
);
    import kne_pkg::*;

    kne_cmd_t cmd;
    kne_sts_t sts;

    // Sequence the line walk
    kne_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (keys.valid),
        .in_ready (keys.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Hold entry state and the result word
    kne_datapath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .key_levels    (keys.key_levels),
        .cmd           (cmd),
        .sts           (sts),
        .out_ready     (result.ready),
        .out_valid     (result.valid),
        .entered_value (result.entered_value)
    );

    `KNE_ASSERT(a_one_cmd, $onehot0({cmd.load, cmd.step, cmd.emit}), "kne: more than one command")
    `KNE_ASSERT(a_emit_free, cmd.emit |-> sts.out_free, "kne: result word overwritten")
    `KNE_ASSERT_NEXT(a_busy_after_accept, keys.valid && keys.ready, !keys.ready, "kne: not busy")
    `KNE_ASSERT_NEXT(a_emit_shows, cmd.emit, result.valid, "kne: emitted word not shown")
endmodule

### rtl/core/kne_ctrl.sv
module kne_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  kne_pkg::kne_sts_t sts,
    output kne_pkg::kne_cmd_t cmd
);
    import kne_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic state_reg;
    logic state_next;

    // Sequence one scan: load, then walk the lines one per cycle, holding on hash until the output slot is free
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (sts.hash_release)
                begin
                    // hold on hash until the output word slot is free
                    if (sts.out_free)
                    begin
                        cmd.emit   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.step = 1'b1;
                    if (sts.last_line)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

### rtl/core/kne_datapath.sv
module kne_datapath #(
    parameter int MAX_DIGITS = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [kne_pkg::LINE_COUNT-1:0]       key_levels,
    input  kne_pkg::kne_cmd_t                    cmd,
    output kne_pkg::kne_sts_t                    sts,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic signed [kne_pkg::OUT_W-1:0]     entered_value
);
    import kne_pkg::*;

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    logic [LINE_COUNT-1:0]   levels_reg;
    logic [LINE_COUNT-1:0]   marks_reg;
    logic [LINE_COUNT-1:0]   marks_next;
    logic [VALUE_W-1:0]      value_reg;
    logic [VALUE_W-1:0]      value_next;
    logic [CNT_W-1:0]        count_reg;
    logic [CNT_W-1:0]        count_next;
    logic [LINE_W-1:0]       line_reg;
    logic [LINE_W-1:0]       line_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic signed [OUT_W-1:0] out_data_reg;

    logic               pressed;
    logic               marked;
    logic               released;
    logic [VALUE_W-1:0] value_x10;
    logic [VALUE_W-1:0] value_append;

    // Look at the current line
    assign pressed  = levels_reg[line_reg];
    assign marked   = marks_reg[line_reg];
    assign released = !pressed && marked;

    // Shift the decimal value one digit and add the line's digit
    assign value_x10    = VALUE_W'((value_reg << 3) + (value_reg << 1));
    assign value_append = VALUE_W'(value_x10 + VALUE_W'(line_digit(line_reg)));

    assign sts.hash_release = released && (line_reg == HASH_LINE);
    assign sts.last_line    = (line_reg == LAST_LINE);
    assign sts.out_free     = !out_valid_reg || out_ready;

    // Update marks, value, count and line for one line step; clear them on emit, restart the line on load
    always_comb
    begin
        marks_next     = marks_reg;
        value_next     = value_reg;
        count_next     = count_reg;
        line_next      = line_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.load)
        begin
            line_next = '0;
        end
        else if (cmd.emit)
        begin
            marks_next     = '0;
            value_next     = '0;
            count_next     = '0;
            line_next      = '0;
            out_valid_next = 1'b1;
        end
        else if (cmd.step)
        begin
            if (pressed && !marked)
            begin
                marks_next[line_reg] = 1'b1;
            end
            else if (released)
            begin
                marks_next[line_reg] = 1'b0;
                // drop digits past the limit
                if (count_reg < CNT_W'(MAX_DIGITS))
                begin
                    value_next = value_append;
                    count_next = CNT_W'(count_reg + 1'b1);
                end
            end
            line_next = sts.last_line ? '0 : LINE_W'(line_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marks_reg     <= '0;
            value_reg     <= '0;
            count_reg     <= '0;
            line_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            marks_reg     <= marks_next;
            value_reg     <= value_next;
            count_reg     <= count_next;
            line_reg      <= line_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the scan and the result word
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            levels_reg <= key_levels;
        end
        if (cmd.emit)
        begin
            out_data_reg <= (count_reg == '0) ? '1 : $signed({1'b0, value_reg});
        end
    end

    assign out_valid     = out_valid_reg;
    assign entered_value = out_data_reg;
endmodule
